/* rtl/tta_pkg.sv */
// Package for the toggle trackball accelerator: shared types, widths and step table.
// No dependencies; imported by the lane and the top level.
`default_nettype none
package tta_pkg;

    localparam int STEP_W    = 22;
    localparam int IN_BYTES  = 5;
    localparam int OUT_BYTES = 6;
    localparam int NOW_W     = 32;
    localparam int TABLE_TOP = 33;
    localparam int IDX_W     = 6;

    localparam logic [STEP_W-1:0] FAR_STEP = STEP_W'(2);

    typedef logic signed [STEP_W-1:0] t_step;

    typedef struct packed {
        logic accept;
        logic primed;
    } t_lane_ctl;

    function automatic logic [STEP_W-1:0] step_mag(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] mag;
        case (idx)
            6'd1:  mag = STEP_W'(1736299);
            6'd2:  mag = STEP_W'(1863);
            6'd3:  mag = STEP_W'(190);
            6'd4:  mag = STEP_W'(61);
            6'd5:  mag = STEP_W'(30);
            6'd6:  mag = STEP_W'(19);
            6'd7:  mag = STEP_W'(14);
            6'd8:  mag = STEP_W'(11);
            6'd9:  mag = STEP_W'(9);
            6'd10: mag = STEP_W'(7);
            6'd11: mag = STEP_W'(6);
            6'd12: mag = STEP_W'(6);
            6'd13: mag = STEP_W'(5);
            6'd14: mag = STEP_W'(5);
            6'd15: mag = STEP_W'(4);
            6'd16: mag = STEP_W'(4);
            6'd17: mag = STEP_W'(4);
            6'd18: mag = STEP_W'(4);
            6'd19: mag = STEP_W'(4);
            6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26,
            6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33: mag = STEP_W'(3);
            default: mag = FAR_STEP;
        endcase
        return mag;
    endfunction

endpackage
`default_nettype wire

/* rtl/trackball_toggle_accelerator.sv */
// Top level of the toggle trackball accelerator: two axis lanes, merge and output register.
// Depends on tta_pkg and tta_lane.
//
// Takes one sensor sample per clock and returns one result per sample in the cycle after
// the input transfer; throughput is one item per cycle while the output side accepts.
// Each lane compares its two pins, subtracts the stored change time and looks up the
// step in a 33-entry table in the same cycle; the merge stage forms the moved flag and
// feeds a single output register. The first sample after reset only primes the lanes
// and returns zero steps.
`default_nettype none
module trackball_toggle_accelerator #(
    parameter int TIME_WIDTH = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    // [0] left_level, [1] right_level, [2] up_level, [3] down_level, [35:4] now_ms
    input  wire [39:0] s_axis_tdata,
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    // [21:0] x_step, [43:22] y_step, [44] moved
    output logic [47:0] m_axis_tdata
);
    import tta_pkg::*;

    logic                  r_primed;
    logic                  r_valid;
    t_step                 r_x;
    t_step                 r_y;
    logic                  r_moved;

    logic                  accept;
    logic [63:0]           now_wide;
    logic [TIME_WIDTH-1:0] now_t;
    t_lane_ctl             ctl;
    t_step                 x_step;
    t_step                 y_step;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign now_wide      = {32'b0, s_axis_tdata[35:4]};
    assign now_t         = now_wide[TIME_WIDTH-1:0];
    assign ctl           = '{accept: accept, primed: r_primed};

    tta_lane #(.TIME_WIDTH(TIME_WIDTH)) u_lane_x (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_lo_level (s_axis_tdata[0]),
        .i_hi_level (s_axis_tdata[1]),
        .i_now      (now_t),
        .o_step     (x_step)
    );

    tta_lane #(.TIME_WIDTH(TIME_WIDTH)) u_lane_y (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_lo_level (s_axis_tdata[2]),
        .i_hi_level (s_axis_tdata[3]),
        .i_now      (now_t),
        .o_step     (y_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_primed <= 1'b1;
                r_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x     <= x_step;
            r_y     <= y_step;
            r_moved <= (x_step != '0) || (y_step != '0);
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {3'b0, r_moved, r_y, r_x};

endmodule
`default_nettype wire

/* rtl/tta_lane.sv */
// One axis lane of the toggle trackball accelerator: two pins, their last levels and
// change times, and the signed step. Depends on tta_pkg.
`default_nettype none
module tta_lane #(
    parameter int TIME_WIDTH = 32
) (
    input  wire                   i_clk,
    input  wire tta_pkg::t_lane_ctl i_ctl,
    input  wire                   i_lo_level,
    input  wire                   i_hi_level,
    input  wire  [TIME_WIDTH-1:0] i_now,
    output tta_pkg::t_step        o_step
);
    import tta_pkg::*;

    logic [1:0]            r_level;
    logic [TIME_WIDTH-1:0] r_time [2];

    logic                  lo_chg;
    logic                  hi_chg;
    logic                  sel;
    logic [TIME_WIDTH-1:0] delta;
    logic [TIME_WIDTH-1:0] delta_eff;
    logic [STEP_W-1:0]     mag;
    logic [1:0]            cur_level;

    always_comb begin
        cur_level = {i_hi_level, i_lo_level};
        lo_chg    = i_lo_level != r_level[0];
        hi_chg    = i_hi_level != r_level[1];
        sel       = !lo_chg;
        delta     = i_now - r_time[sel];
        delta_eff = (delta == '0) ? TIME_WIDTH'(1) : delta;
        if (delta_eff <= TIME_WIDTH'(TABLE_TOP)) begin
            mag = step_mag(delta_eff[IDX_W-1:0]);
        end else begin
            mag = FAR_STEP;
        end
        if (!i_ctl.primed || !(lo_chg || hi_chg)) begin
            o_step = '0;
        end else if (lo_chg) begin
            o_step = -$signed(mag);
        end else begin
            o_step = $signed(mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            if (!i_ctl.primed) begin
                r_level   <= cur_level;
                r_time[0] <= i_now;
                r_time[1] <= i_now;
            end else if (lo_chg || hi_chg) begin
                r_level[sel] <= cur_level[sel];
                r_time[sel]  <= i_now;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/tta_chk.sv */
// Port checker for the toggle trackball accelerator, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module tta_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [39:0] s_axis_tdata,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [47:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted sample gave no result");

    a_moved_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[44] == ((m_axis_tdata[21:0] != 22'd0)
                                             || (m_axis_tdata[43:22] != 22'd0)))
        else $error("moved flag disagrees with steps");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[21:0]) <= 22'sd1736299)
                       && ($signed(m_axis_tdata[21:0]) >= -22'sd1736299)
                       && ($signed(m_axis_tdata[43:22]) <= 22'sd1736299)
                       && ($signed(m_axis_tdata[43:22]) >= -22'sd1736299)
                       && (m_axis_tdata[47:45] == 3'd0))
        else $error("step out of range or padding set");

endmodule

bind trackball_toggle_accelerator tta_chk u_tta_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
